/* design/input_column_decoder_core_macros.svh */
// Assertion macros for the input column decoder.
`ifndef INPUT_COLUMN_DECODER_CORE_MACROS_SVH
`define INPUT_COLUMN_DECODER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ICD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icd assertion failed");
`define ICD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icd assertion failed");
`else
`define ICD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ICD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/icd_pkg.sv */
// Types and codes shared by the input column decoder.
`default_nettype none
package icd_pkg;
  localparam logic [1:0] OP_DATA   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  localparam logic [1:0] KIND_ACTION = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

  localparam int NUM_SLOTS = 32;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_MASK = 3'd1,
    PH_REC  = 3'd2,
    PH_VAL  = 3'd3,
    PH_DX   = 3'd4,
    PH_DY   = 3'd5,
    PH_DONE = 3'd6,
    PH_ERR  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [15:0] col_frames;
    logic [63:0] first_tick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        frame_index;
    logic [4:0]         action_index;
    logic signed [7:0]  action_value;
    logic [2:0]         action_flags;
    logic signed [31:0] ptr_x;
    logic signed [31:0] ptr_y;
    logic [31:0]        tick;
    logic               last_frame;
    logic [1:0]         error_code;
  } out_item_t;
endpackage
`default_nettype wire

/* design/input_column_decoder_core.sv */
// Input column decoder: mask, records and pointer varints, one byte per item.
// Usage:
//  in_valid/in_stall carry an in_item_t; op selects data byte, start column
//  or end of data. A start item loads frame count and base tick and clears
//  the previous frame, velocities and pointer.
//  out_valid/out_stall carry an out_item_t: action changed, frame complete
//  (pointer, tick, last_frame) or error. After an error the block ignores
//  bytes until the next start item.
//  cfg_valid/cfg_ready write the 64-bit implied value table; cfg_ready is
//  always high. Write it only while the block is idle.
//  Throughput: one item per cycle while in_stall is low. Each byte is decoded
//  by one pass of logic between the input and the output register.
//  A two-entry output stage (output register plus skid register) lets an
//  item be taken while a result waits; in_stall rises only when the skid
//  register holds a result. Items that give no result are always taken
//  unless in_stall is high.
//  Reset (rst_n low, synchronous) empties the output stage, clears the table
//  and returns the decoder to idle.
`default_nettype none
`include "input_column_decoder_core_macros.svh"
module input_column_decoder_core
  import icd_pkg::*;
#(
  parameter int ACTION_LIMIT = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [63:0] cfg_data
);
  localparam logic [32:0] LIMIT = 33'(1) << ACTION_LIMIT;
  localparam logic [31:0] ALLOWED = 32'(LIMIT - 33'd1);

  logic [63:0]  implied_r;
  phase_t       phase_r, phase_nxt;
  logic [34:0]  accum_r, accum_nxt;
  logic [2:0]   shift_r, shift_nxt;
  logic [31:0]  mask_r, mask_nxt;
  logic [4:0]   cur_r, cur_nxt;
  logic [2:0]   pflags_r, pflags_nxt;
  logic [10:0]  prev_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] prev_v_r, prev_v_nxt;
  logic         prev_we;
  logic [10:0]  prev_wdata;
  logic [31:0]  velx_r, velx_nxt, vely_r, vely_nxt;
  logic [31:0]  posx_r, posx_nxt, posy_r, posy_nxt;
  logic [31:0]  hdvx_r, hdvx_nxt;
  logic [15:0]  done_r, done_nxt, total_r, total_nxt;
  logic [31:0]  tbase_r, tbase_nxt;

  logic         out_v_r, skid_v_r;
  out_item_t    out_r, skid_r, res;
  logic         res_v;
  logic         in_acc, out_fire;

  assign in_stall  = skid_v_r;
  assign in_acc    = in_valid && !skid_v_r;
  assign out_fire  = out_v_r && !out_stall;
  assign out_valid = out_v_r;
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

  function automatic logic [4:0] lowest(input logic [31:0] m);
    logic [4:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (m[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic logic [31:0] unzig(input logic [31:0] u);
    return (u >> 1) ^ {32{u[0]}};
  endfunction

  logic [7:0]  b;
  logic [5:0]  shamt;
  logic [34:0] acc_new;
  logic        v_over, v_done;
  logic [31:0] v_val;
  logic [2:0]  c_flags;
  logic [7:0]  c_value;
  logic [10:0] c_prev;
  logic [31:0] m_left;
  logic [31:0] vx_sum, vy_sum;
  logic [15:0] fd_inc;

  always_comb begin
    b       = in_item.data_byte;
    shamt   = {shift_r, 3'b000} - {3'b000, shift_r};
    acc_new = (accum_r | (35'(b[6:0]) << shamt));
    v_over  = (shift_r >= 3'd4) && (b[7:4] != 4'd0);
    v_done  = !b[7];
    v_val   = acc_new[31:0];
    c_flags = (phase_r == PH_VAL) ? pflags_r : b[2:0];
    c_value = (phase_r == PH_VAL) ? b : implied_r[{b[2:0], 3'b000} +: 8];
    c_prev  = prev_v_r[cur_r] ? prev_r[cur_r] : 11'd0;
    m_left  = mask_r & ~(32'd1 << cur_r);
    vx_sum  = velx_r + hdvx_r;
    vy_sum  = vely_r + unzig(v_val);
    fd_inc  = done_r + 16'd1;

    phase_nxt = phase_r;   accum_nxt = accum_r;  shift_nxt = shift_r;
    mask_nxt = mask_r;     cur_nxt = cur_r;      pflags_nxt = pflags_r;
    prev_v_nxt = prev_v_r; prev_we = 1'b0;       prev_wdata = {c_flags, c_value};
    velx_nxt = velx_r;     vely_nxt = vely_r;    posx_nxt = posx_r;
    posy_nxt = posy_r;     hdvx_nxt = hdvx_r;    done_nxt = done_r;
    total_nxt = total_r;   tbase_nxt = tbase_r;

    res = '0;
    res.frame_index = done_r;
    res.tick = tbase_r + 32'(done_r);
    res_v = 1'b0;

    if (in_acc) begin
      if (in_item.op == OP_START) begin
        prev_v_nxt = '0;
        velx_nxt = '0; vely_nxt = '0; posx_nxt = '0; posy_nxt = '0;
        hdvx_nxt = '0; accum_nxt = '0; shift_nxt = '0; mask_nxt = '0;
        cur_nxt = '0; pflags_nxt = '0; done_nxt = '0;
        total_nxt = in_item.col_frames;
        tbase_nxt = in_item.first_tick[31:0];
        phase_nxt = (in_item.col_frames == 16'd0) ? PH_DONE : PH_MASK;
      end else if (in_item.op == OP_IGNORE) begin
        phase_nxt = phase_r;
      end else if (phase_r inside {PH_IDLE, PH_DONE, PH_ERR}) begin
        phase_nxt = phase_r;
      end else if (in_item.op == OP_END) begin
        res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_TRUNCATED;
        phase_nxt = PH_ERR;
      end else begin
        case (phase_r)
          PH_MASK, PH_DX, PH_DY: begin
            if (v_over) begin
              res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_OVERFLOW;
              phase_nxt = PH_ERR;
            end else if (!v_done) begin
              accum_nxt = acc_new;
              shift_nxt = shift_r + 3'd1;
            end else begin
              accum_nxt = '0;
              shift_nxt = '0;
              if (phase_r == PH_MASK) begin
                if ((v_val & ~ALLOWED) != 32'd0) begin
                  res_v = 1'b1; res.kind = KIND_ERROR;
                  res.error_code = ERR_MALFORMED;
                  phase_nxt = PH_ERR;
                end else begin
                  mask_nxt = v_val;
                  phase_nxt = (v_val == 32'd0) ? PH_DX : PH_REC;
                  if (v_val != 32'd0) cur_nxt = lowest(v_val);
                end
              end else if (phase_r == PH_DX) begin
                hdvx_nxt = unzig(v_val);
                phase_nxt = PH_DY;
              end else begin
                velx_nxt = vx_sum;
                vely_nxt = vy_sum;
                posx_nxt = posx_r + vx_sum;
                posy_nxt = posy_r + vy_sum;
                res_v = 1'b1; res.kind = KIND_FRAME;
                res.ptr_x = posx_r + vx_sum;
                res.ptr_y = posy_r + vy_sum;
                done_nxt = fd_inc;
                res.last_frame = (fd_inc >= total_r);
                phase_nxt = (fd_inc >= total_r) ? PH_DONE : PH_MASK;
              end
            end
          end
          PH_REC, PH_VAL: begin
            if (phase_r == PH_REC && b[7:4] != 4'd0) begin
              res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_MALFORMED;
              phase_nxt = PH_ERR;
            end else if (phase_r == PH_REC && b[3]) begin
              pflags_nxt = b[2:0];
              phase_nxt = PH_VAL;
            end else if ((phase_r == PH_VAL &&
                          b == implied_r[{pflags_r, 3'b000} +: 8]) ||
                         c_prev == {c_flags, c_value}) begin
              res_v = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_MALFORMED;
              phase_nxt = PH_ERR;
            end else begin
              prev_we = 1'b1;
              prev_v_nxt[cur_r] = 1'b1;
              mask_nxt = m_left;
              phase_nxt = (m_left == 32'd0) ? PH_DX : PH_REC;
              if (m_left != 32'd0) cur_nxt = lowest(m_left);
              res_v = 1'b1; res.kind = KIND_ACTION;
              res.action_index = cur_r;
              res.action_value = c_value;
              res.action_flags = c_flags;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      implied_r <= '0;
      phase_r <= PH_IDLE; accum_r <= '0; shift_r <= '0; mask_r <= '0;
      cur_r <= '0; pflags_r <= '0; prev_v_r <= '0;
      velx_r <= '0; vely_r <= '0; posx_r <= '0; posy_r <= '0; hdvx_r <= '0;
      done_r <= '0; total_r <= '0; tbase_r <= '0;
      out_v_r <= 1'b0; skid_v_r <= 1'b0;
    end else begin
      if (cfg_valid) implied_r <= cfg_data;
      phase_r <= phase_nxt; accum_r <= accum_nxt; shift_r <= shift_nxt;
      mask_r <= mask_nxt; cur_r <= cur_nxt; pflags_r <= pflags_nxt;
      prev_v_r <= prev_v_nxt;
      velx_r <= velx_nxt; vely_r <= vely_nxt; posx_r <= posx_nxt;
      posy_r <= posy_nxt; hdvx_r <= hdvx_nxt;
      done_r <= done_nxt; total_r <= total_nxt; tbase_r <= tbase_nxt;
      if (skid_v_r) begin
        if (out_fire) begin
          out_r <= skid_r;
          skid_v_r <= 1'b0;
        end
      end else if (res_v) begin
        if (!out_v_r || out_fire) begin
          out_r <= res;
          out_v_r <= 1'b1;
        end else begin
          skid_r <= res;
          skid_v_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_r[cur_r] <= prev_wdata;
  end

  `ICD_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r)
  `ICD_ASSERT_SAME(a_frames_bound, clk, rst_n, 1'b1, done_r <= total_r)
  `ICD_ASSERT_NEXT(a_err_sticky, clk, rst_n, phase_r == PH_ERR && !(in_acc && in_item.op == OP_START), phase_r == PH_ERR)
endmodule
`default_nettype wire
